### sv/uvc_pkg.sv
`default_nettype none
package uvc_pkg;

	localparam int IW      = 12;       // vertex index width
	localparam int NC_W    = 13;       // node count register width
	localparam int ENTRY_W = IW + 1;   // used bit on top of the new index
	localparam int Q_DEPTH = 2;        // command queue entries

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_MARK  = 2'd1,
		OP_NODE  = 2'd2,
		OP_REMAP = 2'd3
	} op_e;

	localparam logic KIND_NODE = 1'b0;
	localparam logic KIND_TRI  = 1'b1;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CLEAR,
		B_MARK,
		B_NODE,
		B_TRI,
		B_TRI_OUT
	} bst_e;

	typedef struct packed {
		op_e              operation;
		logic [IW-1:0]    vertex_a;
		logic [IW-1:0]    vertex_b;
		logic [IW-1:0]    vertex_c;
		logic [63:0]      coord_x;
		logic [63:0]      coord_y;
		logic [63:0]      coord_z;
	} item_t;

	typedef struct packed {
		logic             result_kind;
		logic [IW-1:0]    new_a;
		logic [IW-1:0]    new_b;
		logic [IW-1:0]    new_c;
		logic [63:0]      out_x;
		logic [63:0]      out_y;
		logic [63:0]      out_z;
		logic             index_error;
	} res_t;

	// classified command handed from the front to the back
	typedef struct packed {
		op_e                  op;
		logic [2:0][IW-1:0]   vtx;       // vtx[0] is vertex a
		logic [2:0]           inr;       // vertex below the effective count
		logic [63:0]          x;
		logic [63:0]          y;
		logic [63:0]          z;
	} cmd_t;

	// queue status seen by the back
	typedef struct packed {
		logic valid;
		logic full;
	} qstat_t;

endpackage
`default_nettype wire

### sv/uvc_ram.sv
`default_nettype none
module uvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

### sv/uvc_front.sv
`default_nettype none
module uvc_front #(
	parameter int MAX_NODES = 4096,
	parameter int CW        = 13
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire uvc_pkg::item_t         item,
	input  wire logic                   cfg_valid,
	input  wire logic [uvc_pkg::NC_W-1:0] cfg_data,
	input  wire logic                   q_full,
	input  wire logic                   init_busy,
	output logic                        cfg_ready,
	output logic                        busy,
	output logic                        push,
	output uvc_pkg::cmd_t               cmd,
	output logic      [CW-1:0]          eff_cnt
);
	import uvc_pkg::*;

	logic [NC_W-1:0] node_count_q;
	logic [CW-1:0]   cnt_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	// counts above the store depth act as the depth
	assign cnt_ext = CW'(node_count_q);
	assign eff_cnt = (cnt_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : cnt_ext;

	assign busy = q_full || init_busy;
	assign push = start && !busy;

	always_comb begin
		cmd.op     = item.operation;
		cmd.vtx[0] = item.vertex_a;
		cmd.vtx[1] = item.vertex_b;
		cmd.vtx[2] = item.vertex_c;
		cmd.inr[0] = CW'(item.vertex_a) < eff_cnt;
		cmd.inr[1] = CW'(item.vertex_b) < eff_cnt;
		cmd.inr[2] = CW'(item.vertex_c) < eff_cnt;
		cmd.x      = item.coord_x;
		cmd.y      = item.coord_y;
		cmd.z      = item.coord_z;
	end

endmodule
`default_nettype wire

### sv/uvc_queue.sv
`default_nettype none
module uvc_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire uvc_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output uvc_pkg::cmd_t      head,
	output uvc_pkg::qstat_t    stat
);
	import uvc_pkg::*;

	localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCW = $clog2(Q_DEPTH + 1);

	cmd_t             ent_q [Q_DEPTH];
	logic [QAW-1:0]   wr_q;
	logic [QAW-1:0]   rd_q;
	logic [QCW-1:0]   cnt_q;

	assign head       = ent_q[rd_q];
	assign stat.valid = (cnt_q != '0);
	assign stat.full  = (cnt_q == QCW'(Q_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QAW'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QAW'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/uvc_back.sv
`default_nettype none
module uvc_back #(
	parameter int MAX_NODES = 4096,
	parameter int CW        = 13
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire uvc_pkg::cmd_t   head,
	input  wire uvc_pkg::qstat_t stat,
	input  wire logic [CW-1:0]   eff_cnt,
	output logic                 pop,
	output logic                 init_busy,
	output logic                 result_strobe,
	output uvc_pkg::res_t        result
);
	import uvc_pkg::*;

	localparam int AW = $clog2(MAX_NODES);

	bst_e               state_q, state_d;
	logic [1:0]         step_q;
	logic [AW-1:0]      clr_q;
	logic [CW-1:0]      pos_q;
	logic [IW-1:0]      kept_q;
	logic               init_q;
	logic               ok_q;
	logic               err_q;
	logic [IW-1:0]      na_q;
	logic [IW-1:0]      nb_q;
	res_t               res_q;
	logic               strobe_q;

	logic               ram_en, ram_we;
	logic [AW-1:0]      ram_addr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	logic [IW-1:0]      vsel;
	logic               insel;
	logic               oksel;
	logic               clr_done;
	logic               hit;
	logic [IW-1:0]      hit_idx;
	logic               emit;
	res_t               emit_res;

	uvc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_NODES)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign vsel     = head.vtx[step_q];
	assign insel    = head.inr[step_q];
	// a vertex renumbers only once its node item has gone by
	assign oksel    = insel && (CW'(vsel) < pos_q);
	assign clr_done = (clr_q == AW'(MAX_NODES - 1));
	assign hit      = ok_q && ram_rdata[ENTRY_W-1];
	assign hit_idx  = hit ? ram_rdata[IW-1:0] : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_done) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (stat.valid) begin
					case (head.op)
						OP_BEGIN: state_d = B_CLEAR;
						OP_MARK:  state_d = (pos_q != '0) ? B_IDLE : B_MARK;
						OP_NODE:  state_d = (pos_q >= eff_cnt) ? B_IDLE : B_NODE;
						OP_REMAP: state_d = B_TRI;
						default:  state_d = B_IDLE;
					endcase
				end
			end
			B_MARK: begin
				if (step_q == 2'd2) state_d = B_IDLE;
			end
			B_NODE:    state_d = B_IDLE;
			B_TRI: begin
				if (step_q == 2'd2) state_d = B_TRI_OUT;
			end
			B_TRI_OUT: state_d = B_IDLE;
			default:   state_d = B_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = AW'(pos_q);
		ram_wdata = '0;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_res  = '0;
		case (state_q)
			B_CLEAR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = clr_q;
				pop      = clr_done && !init_q;
			end
			B_IDLE: begin
				if (stat.valid) begin
					case (head.op)
						OP_MARK: pop = (pos_q != '0);
						OP_NODE: begin
							if (pos_q >= eff_cnt) begin
								pop = 1'b1;
							end else begin
								ram_en = 1'b1;
							end
						end
						default: pop = 1'b0;
					endcase
				end
			end
			B_MARK: begin
				ram_en    = insel;
				ram_we    = 1'b1;
				ram_addr  = AW'(vsel);
				ram_wdata = {1'b1, {IW{1'b0}}};
				pop       = (step_q == 2'd2);
			end
			B_NODE: begin
				pop = 1'b1;
				if (ram_rdata[ENTRY_W-1]) begin
					ram_en               = 1'b1;
					ram_we               = 1'b1;
					ram_wdata            = {1'b1, kept_q};
					emit                 = 1'b1;
					emit_res.result_kind = KIND_NODE;
					emit_res.new_a       = kept_q;
					emit_res.out_x       = head.x;
					emit_res.out_y       = head.y;
					emit_res.out_z       = head.z;
				end
			end
			B_TRI: begin
				ram_en   = insel;
				ram_addr = AW'(vsel);
			end
			B_TRI_OUT: begin
				pop                  = 1'b1;
				emit                 = 1'b1;
				emit_res.result_kind = KIND_TRI;
				emit_res.new_a       = na_q;
				emit_res.new_b       = nb_q;
				emit_res.new_c       = hit_idx;
				emit_res.index_error = err_q || !hit;
			end
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_CLEAR;
			step_q   <= '0;
			clr_q    <= '0;
			pos_q    <= '0;
			kept_q   <= '0;
			init_q   <= 1'b1;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if ((state_q == B_MARK || state_q == B_TRI) && step_q != 2'd2) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (state_q == B_CLEAR && !clr_done) begin
				clr_q <= clr_q + 1'b1;
			end else begin
				clr_q <= '0;
			end
			if (state_q == B_CLEAR && clr_done) begin
				init_q <= 1'b0;
			end
			if (state_q == B_IDLE && stat.valid && head.op == OP_BEGIN) begin
				pos_q  <= '0;
				kept_q <= '0;
			end else if (state_q == B_NODE) begin
				pos_q <= pos_q + 1'b1;
				if (ram_rdata[ENTRY_W-1]) begin
					kept_q <= kept_q + 1'b1;
				end
			end
		end
	end

	// triangle gather, one store read per vertex
	always_ff @(posedge clk) begin
		if (state_q == B_TRI) begin
			ok_q <= oksel;
			case (step_q)
				2'd0:    err_q <= 1'b0;
				2'd1: begin
					na_q  <= hit_idx;
					err_q <= err_q || !hit;
				end
				2'd2: begin
					nb_q  <= hit_idx;
					err_q <= err_q || !hit;
				end
				default: err_q <= err_q;
			endcase
		end
		if (emit) begin
			res_q <= emit_res;
		end
	end

	assign init_busy     = init_q;
	assign result_strobe = strobe_q;
	assign result        = res_q;

endmodule
`default_nettype wire

### sv/unused_vertex_compaction_remap.sv
// channel   | ports                              | handshake
// ----------+------------------------------------+----------------------------------
// item in   | start, busy, item                  | beat taken when start && !busy
// config    | cfg_valid, cfg_ready, cfg_data     | beat taken when cfg_valid && cfg_ready
// result    | result_strobe, result              | one-cycle strobe, no back-pressure
//
// flow: the front classifies an item in its accept cycle and queues it; the back then
//   rewrites a node's entry, marks or reads up to three vertices for a mark or a triangle
//   and pops a skipped item, over the vertex store's single port (one access per cycle)
// a begin sweeps the whole vertex store, clearing every entry
// reset: busy stays high during a clearing pass over the whole vertex store
// stalls: busy rises when the two-entry command queue is full or while the store clears
//   after reset; results leave through an output register, and the receiver cannot stall
`default_nettype none
module unused_vertex_compaction_remap #(
	parameter int MAX_NODES = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire uvc_pkg::item_t           item,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [uvc_pkg::NC_W-1:0] cfg_data,
	output logic                          result_strobe,
	output uvc_pkg::res_t                 result
);
	import uvc_pkg::*;

	// counters must hold both the register range and the store depth
	localparam int CW = ($clog2(MAX_NODES + 1) > NC_W) ? $clog2(MAX_NODES + 1) : NC_W;

	cmd_t          push_cmd;
	cmd_t          head;
	qstat_t        stat;
	logic          push;
	logic          pop;
	logic          init_busy;
	logic [CW-1:0] eff_cnt;

	// front: config register, range checks against the node count, accept
	uvc_front #(
		.MAX_NODES (MAX_NODES),
		.CW        (CW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.q_full    (stat.full),
		.init_busy (init_busy),
		.cfg_ready (cfg_ready),
		.busy      (busy),
		.push      (push),
		.cmd       (push_cmd),
		.eff_cnt   (eff_cnt)
	);

	// short queue so the front keeps taking beats while the back works
	uvc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	// back: sequencer over the vertex store (used bit plus new index per entry)
	uvc_back #(
		.MAX_NODES (MAX_NODES),
		.CW        (CW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.stat          (stat),
		.eff_cnt       (eff_cnt),
		.pop           (pop),
		.init_busy     (init_busy),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule
`default_nettype wire

### sv/uvc_checker.sv
`default_nettype none
module uvc_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          busy,
	input  wire logic          cfg_valid,
	input  wire logic          cfg_ready,
	input  wire logic          result_strobe,
	input  wire uvc_pkg::res_t result
);
	import uvc_pkg::*;

	// store clearing holds off items right after reset
	a_busy_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> busy)
		else $error("busy low right after reset");

	// every result ends a sequencer pass, so strobes never touch
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("back-to-back result strobes");

	a_node_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.result_kind == KIND_NODE) |->
		(!result.index_error && result.new_b == '0 && result.new_c == '0))
		else $error("kept node beat carries triangle fields");

	a_tri_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.result_kind == KIND_TRI) |->
		(result.out_x == '0 && result.out_y == '0 && result.out_z == '0))
		else $error("triangle beat carries coordinates");

	// node count register takes a config beat in any cycle
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config beat held off");

endmodule

bind unused_vertex_compaction_remap uvc_checker u_uvc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.busy          (busy),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready),
	.result_strobe (result_strobe),
	.result        (result)
);
`default_nettype wire
